@@ rtl/core/lamport_mutex_node_unit_macros.svh @@
// ============================================================================
// lamport_mutex_node_unit_macros.svh
// Assertion macros shared by the checker of the mutex node.
// ============================================================================
`ifndef LAMPORT_MUTEX_NODE_UNIT_MACROS_SVH
`define LAMPORT_MUTEX_NODE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LMN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lamport mutex node: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LMN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lamport mutex node: next-cycle check failed");

`endif

@@ rtl/core/lmn_pkg.sv @@
// ============================================================================
// lmn_pkg
// Types and codes shared by the Lamport mutual exclusion node.
// ============================================================================
package lmn_pkg;

    // Input modes
    localparam logic [1:0] MODE_WISH    = 2'd0;
    localparam logic [1:0] MODE_REQUEST = 2'd1;
    localparam logic [1:0] MODE_REPLY   = 2'd2;
    localparam logic [1:0] MODE_RELEASE = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_NODE_ID     = 2'd0;
    localparam logic [1:0] REG_NODE_COUNT  = 2'd1;
    localparam logic [1:0] REG_CLOCK_START = 2'd2;

    // Reset values
    localparam logic [4:0]  NODE_ID_RST    = 5'd1;
    localparam logic [4:0]  NODE_COUNT_RST = 5'd3;
    localparam logic [31:0] CLOCK_RST      = 32'd80;
    localparam logic [4:0]  REPLY_MAX      = 5'd31;
    localparam logic [31:0] CLOCK_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  peer_id;
        logic [31:0] stamp;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [4:0]  out_node;
        logic [31:0] out_stamp;
        logic        last;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the accepted item
        logic exec;     // apply the item to clock, queue and counters
        logic check;    // grant check, pops the head on a grant
        logic sel_rel;  // push the release rather than the first result
        logic last;     // mark the pushed result as final
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic has_res;  // the item produced a request or reply
        logic grant;    // the grant check fired
    } dp_stat_t;

endpackage

@@ rtl/core/lmn_if.sv @@
// ============================================================================
// lmn_if
// Valid/ready channel interfaces of the mutex node.
// ============================================================================
interface lmn_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [4:0]  peer_id;
    logic [31:0] stamp;

    modport source (output valid, output mode, output peer_id, output stamp, input ready);
    modport sink   (input valid, input mode, input peer_id, input stamp, output ready);
endinterface

interface lmn_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [4:0]  out_node;
    logic [31:0] out_stamp;
    logic        last;

    modport source (output valid, output out_kind, output out_node, output out_stamp,
                    output last, input ready);
    modport sink   (input valid, input out_kind, input out_node, input out_stamp,
                    input last, output ready);
endinterface

interface lmn_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/lmn_ctrl.sv @@
// ============================================================================
// lmn_ctrl
// Sequencer of the mutex node: accept, execute, grant check, push results.
// ============================================================================
module lmn_ctrl
    import lmn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    input  logic     obuf_full,
    output dp_cmd_t  cmd,
    output logic     push
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_PUSH0 = 3'd3;
    localparam logic [2:0] S_PUSH1 = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        push        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = S_PUSH0;
            end
            S_PUSH0:
            begin
                // first result, or straight on to the release
                if (!stat.has_res)
                begin
                    state_next = stat.grant ? S_PUSH1 : S_IDLE;
                end
                else if (!obuf_full)
                begin
                    push       = 1'b1;
                    cmd.last   = !stat.grant;
                    state_next = stat.grant ? S_PUSH1 : S_IDLE;
                end
            end
            S_PUSH1:
            begin
                cmd.sel_rel = 1'b1;
                cmd.last    = 1'b1;
                if (!obuf_full)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/lmn_dp.sv @@
// ============================================================================
// lmn_dp
// Datapath of the mutex node: config, Lamport clock, sorted request queue,
// reply counter and grant check.
// ============================================================================
module lmn_dp
    import lmn_pkg::*;
#(
    parameter int MAX_NODES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  in_item_t    in_item,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output out_item_t   push_item
);

    localparam int CW = $clog2(MAX_NODES + 1);

    // configuration
    logic [4:0]  node_id_reg;
    logic [4:0]  node_count_reg;
    // node state
    logic [31:0] clock_reg,    clock_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [4:0]  reply_reg,    reply_next;
    logic        await_reg,    await_next;
    logic [31:0] own_stamp_reg, own_stamp_next;
    logic        has_res_reg,  has_res_next;
    logic        grant_reg,    grant_next;
    // captured item and first result
    in_item_t    item_reg;
    logic [1:0]  res_kind_reg, res_kind_next;
    logic [4:0]  res_node_reg, res_node_next;
    logic [31:0] res_stamp_reg, res_stamp_next;
    // queue cells
    logic [31:0] q_stamp_reg [MAX_NODES];
    logic [4:0]  q_node_reg  [MAX_NODES];
    logic [31:0] q_stamp_next [MAX_NODES];
    logic [4:0]  q_node_next  [MAX_NODES];

    // queue shift helpers
    logic [31:0] up_stamp [MAX_NODES];
    logic [4:0]  up_node  [MAX_NODES];
    logic [31:0] dn_stamp [MAX_NODES];
    logic [4:0]  dn_node  [MAX_NODES];
    logic [MAX_NODES-1:0] occ;
    logic [MAX_NODES-1:0] ahead;
    logic [MAX_NODES-1:0] ahead_prev;
    logic [MAX_NODES-1:0] match;
    logic [MAX_NODES-1:0] after;
    logic        ins_en;
    logic        rem_en;
    logic [31:0] ins_stamp;
    logic [4:0]  ins_node;
    logic [31:0] upd_max;
    logic [31:0] clock_upd;
    logic [4:0]  need;
    logic        grant_now;
    logic        q_full;

    // Clock update: max(clock, stamp) + 1, saturating
    assign upd_max   = (clock_reg < item_reg.stamp) ? item_reg.stamp : clock_reg;
    assign clock_upd = (upd_max == CLOCK_MAX) ? upd_max : upd_max + 32'd1;

    assign need      = (node_count_reg == 5'd0) ? 5'd0 : node_count_reg - 5'd1;
    assign grant_now = (count_reg != '0) && (q_node_reg[0] == node_id_reg)
                       && (reply_reg >= need);
    assign q_full    = (count_reg == CW'(MAX_NODES));

    // Insert key: own entry for a wish, sender entry for a request
    assign ins_stamp = (item_reg.mode == MODE_WISH) ? clock_reg : item_reg.stamp;
    assign ins_node  = (item_reg.mode == MODE_WISH) ? node_id_reg : item_reg.peer_id;

    // Per-cell compare and match flags
    always_comb
    begin
        for (int k = 0; k < MAX_NODES; k++)
        begin
            occ[k]   = (CW'(k) < count_reg);
            ahead[k] = occ[k] && ((ins_stamp < q_stamp_reg[k]) ||
                       ((ins_stamp == q_stamp_reg[k]) && (ins_node < q_node_reg[k])));
            if (cmd.check)
            begin
                match[k] = (k == 0) && grant_now;
            end
            else
            begin
                match[k] = occ[k] && (q_node_reg[k] == item_reg.peer_id);
            end
        end
        for (int k = 0; k < MAX_NODES; k++)
        begin
            after[k] = |(match & ~({MAX_NODES{1'b1}} << (k + 1)));
        end
        ahead_prev[0] = 1'b0;
        up_stamp[0]   = '0;
        up_node[0]    = '0;
        for (int k = 1; k < MAX_NODES; k++)
        begin
            ahead_prev[k] = ahead[k-1];
            up_stamp[k]   = q_stamp_reg[k-1];
            up_node[k]    = q_node_reg[k-1];
        end
        for (int k = 0; k < MAX_NODES - 1; k++)
        begin
            dn_stamp[k] = q_stamp_reg[k+1];
            dn_node[k]  = q_node_reg[k+1];
        end
        dn_stamp[MAX_NODES-1] = q_stamp_reg[MAX_NODES-1];
        dn_node[MAX_NODES-1]  = q_node_reg[MAX_NODES-1];
    end

    // Item execution and grant check
    always_comb
    begin
        clock_next     = clock_reg;
        count_next     = count_reg;
        reply_next     = reply_reg;
        await_next     = await_reg;
        own_stamp_next = own_stamp_reg;
        has_res_next   = has_res_reg;
        grant_next     = grant_reg;
        res_kind_next  = res_kind_reg;
        res_node_next  = res_node_reg;
        res_stamp_next = res_stamp_reg;
        ins_en         = 1'b0;
        rem_en         = 1'b0;

        if (cmd.exec)
        begin
            has_res_next = 1'b0;
            unique case (item_reg.mode)
                MODE_WISH:
                begin
                    if (!await_reg)
                    begin
                        own_stamp_next = clock_reg;
                        await_next     = 1'b1;
                        reply_next     = '0;
                        ins_en         = !q_full;
                        has_res_next   = 1'b1;
                        res_kind_next  = KIND_REQUEST;
                        res_node_next  = node_id_reg;
                        res_stamp_next = clock_reg;
                    end
                end
                MODE_REQUEST:
                begin
                    clock_next     = clock_upd;
                    ins_en         = !q_full;
                    has_res_next   = 1'b1;
                    res_kind_next  = KIND_REPLY;
                    res_node_next  = item_reg.peer_id;
                    res_stamp_next = clock_upd;
                end
                MODE_REPLY:
                begin
                    clock_next = clock_upd;
                    if (reply_reg != REPLY_MAX)
                    begin
                        reply_next = reply_reg + 5'd1;
                    end
                end
                MODE_RELEASE:
                begin
                    clock_next = clock_upd;
                    rem_en     = 1'b1;
                end
                default:
                begin
                    clock_next = clock_reg;
                end
            endcase
        end

        if (cmd.check)
        begin
            grant_next = grant_now;
            rem_en     = grant_now;
            if (grant_now)
            begin
                await_next = 1'b0;
                reply_next = '0;
            end
        end

        if (ins_en)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rem_en && (match != '0))
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Queue cell next values
    always_comb
    begin
        for (int k = 0; k < MAX_NODES; k++)
        begin
            q_stamp_next[k] = q_stamp_reg[k];
            q_node_next[k]  = q_node_reg[k];
            if (ins_en)
            begin
                if (ahead_prev[k])
                begin
                    q_stamp_next[k] = up_stamp[k];
                    q_node_next[k]  = up_node[k];
                end
                else if (ahead[k] || (CW'(k) == count_reg))
                begin
                    q_stamp_next[k] = ins_stamp;
                    q_node_next[k]  = ins_node;
                end
            end
            else if (rem_en && after[k])
            begin
                q_stamp_next[k] = dn_stamp[k];
                q_node_next[k]  = dn_node[k];
            end
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg    <= NODE_ID_RST;
            node_count_reg <= NODE_COUNT_RST;
            clock_reg      <= CLOCK_RST;
            count_reg      <= '0;
            reply_reg      <= '0;
            await_reg      <= 1'b0;
            own_stamp_reg  <= '0;
            has_res_reg    <= 1'b0;
            grant_reg      <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            reply_reg     <= reply_next;
            await_reg     <= await_next;
            own_stamp_reg <= own_stamp_next;
            has_res_reg   <= has_res_next;
            grant_reg     <= grant_next;
            clock_reg     <= clock_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_NODE_ID:     node_id_reg    <= cfg_data[4:0];
                    REG_NODE_COUNT:  node_count_reg <= cfg_data[4:0];
                    REG_CLOCK_START: clock_reg      <= cfg_data;
                    default:         node_id_reg    <= node_id_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        res_kind_reg  <= res_kind_next;
        res_node_reg  <= res_node_next;
        res_stamp_reg <= res_stamp_next;
        for (int k = 0; k < MAX_NODES; k++)
        begin
            q_stamp_reg[k] <= q_stamp_next[k];
            q_node_reg[k]  <= q_node_next[k];
        end
    end

    assign stat.has_res = has_res_reg;
    assign stat.grant   = grant_reg;

    // Result to push
    always_comb
    begin
        if (cmd.sel_rel)
        begin
            push_item.out_kind  = KIND_RELEASE;
            push_item.out_node  = node_id_reg;
            push_item.out_stamp = own_stamp_reg;
        end
        else
        begin
            push_item.out_kind  = res_kind_reg;
            push_item.out_node  = res_node_reg;
            push_item.out_stamp = res_stamp_reg;
        end
        push_item.last = cmd.last;
    end

endmodule

@@ rtl/core/lmn_obuf.sv @@
// ============================================================================
// lmn_obuf
// Two-entry result buffer in front of the output channel.
// ============================================================================
module lmn_obuf
    import lmn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    output logic      full,
    lmn_out_if.source out_ch
);

    out_item_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       pop;

    assign pop  = out_ch.valid && out_ch.ready;
    assign full = (fill_reg == 2'd2);

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Output channel
    assign out_ch.valid     = (fill_reg != '0);
    assign out_ch.out_kind  = mem_reg[rd_ptr_reg].out_kind;
    assign out_ch.out_node  = mem_reg[rd_ptr_reg].out_node;
    assign out_ch.out_stamp = mem_reg[rd_ptr_reg].out_stamp;
    assign out_ch.last      = mem_reg[rd_ptr_reg].last;

endmodule

@@ rtl/core/lamport_mutex_node_unit.sv @@
// ============================================================================
// lamport_mutex_node_unit
// One node of Lamport's distributed mutual exclusion.
// ============================================================================
// Channels: in_ch takes one message or local wish per item (mode, peer_id,
// stamp); out_ch gives zero to two result items per input, the final one
// flagged by last; cfg_ch writes node_id, node_count and clock_start and is
// always ready (writing clock_start also loads the Lamport clock).
// Timing: an input is accepted in the idle state, executed in the next cycle
// and grant-checked in the one after; each result then enters a two-entry
// output buffer from a push state, the release from a second push state
// that follows when the grant check fires. The sorted insert and removal
// work on all queue cells at once, so queue depth adds no states.
// Reset: the queue is empty, counters and flags are clear, node_id is 1,
// node_count is 3 and the clock is 80.
// Stalls: while out_ch is stalled the buffer holds up to two results; once
// it is full the node waits in its push state and holds off the input.
// ============================================================================
module lamport_mutex_node_unit
    import lmn_pkg::*;
#(
    parameter int MAX_NODES = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    lmn_in_if.sink    in_ch,
    lmn_out_if.source out_ch,
    lmn_cfg_if.sink   cfg_ch
);

    dp_cmd_t   cmd;
    dp_stat_t  stat;
    out_item_t push_item;
    in_item_t  in_item;
    logic      push;
    logic      obuf_full;

    assign cfg_ch.ready    = 1'b1;
    assign in_item.mode    = in_ch.mode;
    assign in_item.peer_id = in_ch.peer_id;
    assign in_item.stamp   = in_ch.stamp;

    lmn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .stat      (stat),
        .obuf_full (obuf_full),
        .cmd       (cmd),
        .push      (push)
    );

    lmn_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_ch.valid),
        .cfg_index (cfg_ch.index),
        .cfg_data  (cfg_ch.data),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .push_item (push_item)
    );

    lmn_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (obuf_full),
        .out_ch    (out_ch)
    );

endmodule

@@ rtl/core/lmn_checker.sv @@
// ============================================================================
// lmn_checker
// Port-level checks of the mutex node, bound to the top level.
// ============================================================================
`include "lamport_mutex_node_unit_macros.svh"

module lmn_checker
    import lmn_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_kind,
    input logic [4:0]  out_node,
    input logic [31:0] out_stamp,
    input logic        last
);

    // A stalled result holds its payload
    `LMN_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_node) && $stable(out_stamp) && $stable(last))

    // A release is always the final result of its input
    `LMN_ASSERT_IMP(a_release_last, clk, rst_n, out_valid && (out_kind == KIND_RELEASE), last)

    // One item at a time: no accept in the cycle after an accept
    `LMN_ASSERT_NXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

    // The node stays busy for at least the execute and check cycles
    `LMN_ASSERT_NXT(a_busy_two, clk, rst_n, $past(in_valid && in_ready), !in_ready)

endmodule

bind lamport_mutex_node_unit lmn_checker u_lmn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.out_kind),
    .out_node  (out_ch.out_node),
    .out_stamp (out_ch.out_stamp),
    .last      (out_ch.last)
);

@@ bench/tb_lamport_mutex_node_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_lamport_mutex_node_unit
// Self-checking bench for one node of Lamport's distributed mutual exclusion.
// A table of directed items runs first: reset values, clock saturation, tie
// ordering by node, a wish while waiting, releases with no match and a grant
// in the same item as the wish. Random phases follow, each under its own
// register setting. They mostly play a well-formed group of peers around the
// node, with some raw noise mixed in. Every result is checked in order against
// typed row results or a model of the clock, sorted request queue and counters.
// ============================================================================
module tb_lamport_mutex_node_unit;
    import lmn_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 135;
    localparam int POST_IDLE   = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_REPORTS = 10;

    // One row of the directed table: a register setting or an input item
    typedef struct {
        bit          is_cfg;
        logic [4:0]  cfg_node;
        logic [4:0]  cfg_group;
        logic [31:0] cfg_clock;
        in_item_t    item;
        int          typed_n;   // -1: use the model, else typed results below
        out_item_t   r0;
        out_item_t   r1;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    lmn_in_if  in_ch();
    lmn_out_if out_ch();
    lmn_cfg_if cfg_ch();

    lamport_mutex_node_unit #(.MAX_NODES(QUEUE_DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Node model state
    logic [4:0]  own_id;
    logic [4:0]  group_size;
    logic [31:0] lclock;
    logic [31:0] q_stamp [QUEUE_DEPTH];
    logic [4:0]  q_node  [QUEUE_DEPTH];
    int          pend;
    logic [4:0]  replies;
    logic        awaiting;
    logic [31:0] own_stamp;

    out_item_t   step_out[$];
    out_item_t   expected_msgs[$];
    dir_row_t    dir_rows[$];

    // Bench control and statistics
    bit          calm = 1'b0;
    int          hold_seq = 0;
    int          cycle_count = 0;
    int          fail_count = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          items_directed = 0;
    int          grants = 0;
    int          drops = 0;
    int          deepest = 0;
    int          settings = 0;

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still awaited",
                     cycle_count, expected_msgs.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Model of the node
    // ------------------------------------------------------------------------
    task automatic emit(input logic [1:0] kind, input logic [4:0] node,
                        input logic [31:0] stamp);
        out_item_t r;
        r.out_kind  = kind;
        r.out_node  = node;
        r.out_stamp = stamp;
        r.last      = 1'b0;
        step_out.insert(step_out.size(), r);
    endtask

    // Lamport update, saturating at the top
    task automatic bump_clock(input logic [31:0] stamp);
        logic [31:0] m;
        m = (lclock < stamp) ? stamp : lclock;
        lclock = (m == CLOCK_MAX) ? m : m + 32'd1;
    endtask

    // Sorted insert by stamp, then node; a full queue drops the entry
    task automatic queue_insert(input logic [31:0] stamp, input logic [4:0] node);
        int pos;
        pos = 0;
        if (pend >= QUEUE_DEPTH)
        begin
            drops++;
            return;
        end
        while (pos < pend && !((stamp != q_stamp[pos]) ? (stamp < q_stamp[pos])
                                                        : (node < q_node[pos])))
            pos++;
        for (int k = pend; k > pos; k--)
        begin
            q_stamp[k] = q_stamp[k - 1];
            q_node[k]  = q_node[k - 1];
        end
        q_stamp[pos] = stamp;
        q_node[pos]  = node;
        pend++;
        if (pend > deepest)
            deepest = pend;
    endtask

    task automatic remove_at(input int pos);
        for (int k = pos; k + 1 < pend; k++)
        begin
            q_stamp[k] = q_stamp[k + 1];
            q_node[k]  = q_node[k + 1];
        end
        pend--;
    endtask

    // Apply one item, leave its results in step_out
    task automatic node_step(input in_item_t it);
        logic [4:0] need;
        int         hit;
        need = (group_size == 5'd0) ? 5'd0 : group_size - 5'd1;
        hit  = -1;
        step_out.delete();
        case (it.mode)
            MODE_WISH:
            begin
                if (!awaiting)
                begin
                    own_stamp = lclock;
                    awaiting  = 1'b1;
                    replies   = 5'd0;
                    queue_insert(lclock, own_id);
                    emit(KIND_REQUEST, own_id, lclock);
                end
            end
            MODE_REQUEST:
            begin
                bump_clock(it.stamp);
                queue_insert(it.stamp, it.peer_id);
                emit(KIND_REPLY, it.peer_id, lclock);
            end
            MODE_REPLY:
            begin
                bump_clock(it.stamp);
                if (replies != REPLY_MAX)
                    replies = replies + 5'd1;
            end
            default:
            begin
                bump_clock(it.stamp);
                for (int k = 0; k < pend && hit < 0; k++)
                    if (q_node[k] == it.peer_id)
                        hit = k;
                if (hit >= 0)
                    remove_at(hit);
            end
        endcase
        // grant check after every item
        if (pend > 0 && q_node[0] == own_id && replies >= need)
        begin
            remove_at(0);
            awaiting = 1'b0;
            replies  = 5'd0;
            emit(KIND_RELEASE, own_id, own_stamp);
            grants++;
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic offer_item(input in_item_t it, input int typed_n,
                              input out_item_t r0, input out_item_t r1);
        if (!calm && $urandom_range(0, 99) < 10)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= it.mode;
        in_ch.peer_id <= it.peer_id;
        in_ch.stamp   <= it.stamp;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        node_step(it);
        if (typed_n < 0)
        begin
            foreach (step_out[k])
                expected_msgs.insert(expected_msgs.size(), step_out[k]);
        end
        else
        begin
            if (typed_n > 0)
                expected_msgs.insert(expected_msgs.size(), r0);
            if (typed_n > 1)
                expected_msgs.insert(expected_msgs.size(), r1);
        end
        items_sent++;
    endtask

    // Valid stays high across back-to-back writes; caller lowers it
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_NODE_ID:     own_id     = data[4:0];
            REG_NODE_COUNT:  group_size = data[4:0];
            REG_CLOCK_START: lclock     = data;
            default:         ;
        endcase
    endtask

    task automatic apply_setting(input logic [4:0] node, input logic [4:0] group,
                                 input logic [31:0] start, input bit load_clock);
        write_reg(REG_NODE_ID, {27'd0, node});
        write_reg(REG_NODE_COUNT, {27'd0, group});
        if (load_clock)
            write_reg(REG_CLOCK_START, start);
        cfg_ch.valid <= 1'b0;
        settings++;
    endtask

    // Drain all results, then let any result-free item finish inside the node
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_msgs.size() != 0)
            @(posedge clk);
        repeat (POST_IDLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------------
    function automatic out_item_t res(input logic [1:0] kind, input logic [4:0] node,
                                      input logic [31:0] stamp, input logic last);
        out_item_t r;
        r.out_kind  = kind;
        r.out_node  = node;
        r.out_stamp = stamp;
        r.last      = last;
        return r;
    endfunction

    function automatic dir_row_t mk_item(input logic [1:0] mode, input logic [4:0] peer,
                                         input logic [31:0] stamp, input int n = -1,
                                         input out_item_t r0 = '0,
                                         input out_item_t r1 = '0);
        dir_row_t row;
        row.is_cfg       = 1'b0;
        row.cfg_node     = '0;
        row.cfg_group    = '0;
        row.cfg_clock    = '0;
        row.item.mode    = mode;
        row.item.peer_id = peer;
        row.item.stamp   = stamp;
        row.typed_n      = n;
        row.r0           = r0;
        row.r1           = r1;
        return row;
    endfunction

    function automatic dir_row_t mk_cfg(input logic [4:0] node, input logic [4:0] group,
                                        input logic [31:0] start);
        dir_row_t row;
        row           = mk_item(MODE_WISH, 5'd0, 32'd0);
        row.is_cfg    = 1'b1;
        row.cfg_node  = node;
        row.cfg_group = group;
        row.cfg_clock = start;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Random item: mostly a well-formed peer group, some raw noise
    // ------------------------------------------------------------------------
    function automatic in_item_t make_item(input int req_w);
        in_item_t it;
        int       pick;
        int       span;
        int       cand[$];
        pick = $urandom_range(0, 99);
        it.mode    = 2'($urandom_range(0, 3));
        it.peer_id = 5'($urandom_range(0, 31));
        it.stamp   = $urandom;
        if (pick < 15)
        begin
            if ($urandom_range(0, 3) == 0)
                it.stamp = ($urandom_range(0, 1) == 0) ? 32'd0 : CLOCK_MAX;
            return it;
        end
        pick = $urandom_range(0, 99);
        span = (group_size < 5'd2) ? 4 : int'(group_size);
        it.peer_id = 5'($urandom_range(1, span));
        if (it.peer_id == own_id)
            it.peer_id = (int'(it.peer_id) == span) ? 5'd1 : it.peer_id + 5'd1;
        // stamps mostly near the local clock so ties and reordering happen
        case ($urandom_range(0, 9))
            0:       it.stamp = 32'd0;
            1:       it.stamp = CLOCK_MAX;
            2:       it.stamp = $urandom;
            default: it.stamp = lclock + 32'($urandom_range(0, 8)) - 32'd4;
        endcase
        for (int k = 0; k < pend; k++)
            if (q_node[k] != own_id)
                cand.insert(cand.size(), k);
        if (!awaiting && pick < 20)
            it.mode = MODE_WISH;
        else if (pick < 45)
            it.mode = MODE_REPLY;
        else if (pick < 45 + req_w)
            it.mode = MODE_REQUEST;
        else if (cand.size() != 0)
        begin
            it.mode    = MODE_RELEASE;
            it.peer_id = q_node[cand[$urandom_range(0, cand.size() - 1)]];
        end
        else
            it.mode = MODE_REPLY;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls, long hold-offs on request
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen    = 0;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= calm || ($urandom_range(0, 99) >= 10);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.out_kind  = out_ch.out_kind;
            got.out_node  = out_ch.out_node;
            got.out_stamp = out_ch.out_stamp;
            got.last      = out_ch.last;
            results_seen++;
            if (expected_msgs.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("Cycle %0d: unexpected result kind %0d node %0d stamp %h last %0d",
                             cycle_count, got.out_kind, got.out_node, got.out_stamp,
                             got.last);
            end
            else
            begin
                want = expected_msgs[0];
                expected_msgs.delete(0);
                if (got.out_kind !== want.out_kind || got.out_node !== want.out_node ||
                    got.out_stamp !== want.out_stamp || got.last !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("Cycle %0d: expected kind %0d node %0d stamp %h last %0d, %s",
                                 cycle_count, want.out_kind, want.out_node, want.out_stamp,
                                 want.last,
                                 $sformatf("got kind %0d node %0d stamp %h last %0d",
                                           got.out_kind, got.out_node, got.out_stamp,
                                           got.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int req_w;
        in_ch.valid   = 1'b0;
        in_ch.mode    = MODE_WISH;
        in_ch.peer_id = 5'd0;
        in_ch.stamp   = 32'd0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = REG_NODE_ID;
        cfg_ch.data   = 32'd0;
        rst_n         = 1'b0;

        // model state after reset
        own_id     = NODE_ID_RST;
        group_size = NODE_COUNT_RST;
        lclock     = CLOCK_RST;
        pend       = 0;
        replies    = 5'd0;
        awaiting   = 1'b0;
        own_stamp  = 32'd0;
        foreach (q_stamp[k])
        begin
            q_stamp[k] = '0;
            q_node[k]  = '0;
        end

        // reset setting: own request, a wish while waiting, peer ordering
        dir_rows.insert(dir_rows.size(), mk_item(MODE_WISH, 5'd9, 32'h1234_5678, 1,
                                   res(KIND_REQUEST, 5'd1, 32'd80, 1'b1)));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_WISH, 5'd0, 32'd0, 0));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_REPLY, 5'd2, 32'd0));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_REQUEST, 5'd3, 32'd5, 1,
                                   res(KIND_REPLY, 5'd3, 32'd82, 1'b1)));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_REPLY, 5'd3, 32'd100));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_RELEASE, 5'd3, 32'd0, 1,
                                   res(KIND_RELEASE, 5'd1, 32'd80, 1'b1)));
        // release with nothing queued: no grant from an empty queue
        dir_rows.insert(dir_rows.size(), mk_item(MODE_RELEASE, 5'd7, 32'd0, 0));
        // clock saturation and a stamp tie broken by node id
        dir_rows.insert(dir_rows.size(), mk_item(MODE_REPLY, 5'd16, CLOCK_MAX));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_REQUEST, 5'd16, CLOCK_MAX, 1,
                                   res(KIND_REPLY, 5'd16, CLOCK_MAX, 1'b1)));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_WISH, 5'd31, CLOCK_MAX, 1,
                                   res(KIND_REQUEST, 5'd1, CLOCK_MAX, 1'b1)));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_REPLY, 5'd2, 32'd0));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_REPLY, 5'd3, 32'd0, 1,
                                   res(KIND_RELEASE, 5'd1, CLOCK_MAX, 1'b1)));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_RELEASE, 5'd16, 32'd0));
        // ids outside the group, used as given
        dir_rows.insert(dir_rows.size(), mk_item(MODE_REQUEST, 5'd31, 32'h7FFF_FFFF, 1,
                                   res(KIND_REPLY, 5'd31, CLOCK_MAX, 1'b1)));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_REQUEST, 5'd0, 32'd0, 1,
                                   res(KIND_REPLY, 5'd0, CLOCK_MAX, 1'b1)));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_RELEASE, 5'd31, 32'd0));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_RELEASE, 5'd0, 32'd0));
        // single node group: a wish is granted at once, request and release
        dir_rows.insert(dir_rows.size(), mk_cfg(5'd16, 5'd1, 32'd0));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_WISH, 5'd0, 32'd0, 2,
                                   res(KIND_REQUEST, 5'd16, 32'd0, 1'b0),
                                   res(KIND_RELEASE, 5'd16, 32'd0, 1'b1)));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_REQUEST, 5'd5, 32'd0, 1,
                                   res(KIND_REPLY, 5'd5, 32'd1, 1'b1)));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_WISH, 5'd0, 32'd0));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_RELEASE, 5'd5, 32'd3));
        dir_rows.insert(dir_rows.size(), mk_item(MODE_REPLY, 5'd2, 32'hAAAA_AAAA));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                settle();
                apply_setting(dir_rows[i].cfg_node, dir_rows[i].cfg_group,
                              dir_rows[i].cfg_clock, 1'b1);
            end
            else
            begin
                offer_item(dir_rows[i].item, dir_rows[i].typed_n,
                           dir_rows[i].r0, dir_rows[i].r1);
                items_directed++;
            end
        end

        // random phases, one register setting each
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            settle();
            case (p)
                0: apply_setting(5'd2, 5'd3, $urandom, 1'b1);
                1: apply_setting(5'd16, 5'd16, 32'hFFFF_FFF0, 1'b1);
                2: apply_setting(5'd1, 5'd2, 32'd0, 1'b1);
                3: apply_setting(5'd5, 5'd0, $urandom, 1'b1);
                4: apply_setting(5'd31, 5'd31, CLOCK_MAX, 1'b1);
                5: apply_setting(5'd0, 5'd4, $urandom, 1'b1);
                6: apply_setting(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                                 $urandom, 1'b1);
                default: apply_setting(5'($urandom_range(1, 16)),
                                       5'($urandom_range(1, 16)), 32'd0, 1'b0);
            endcase
            // one phase without any idling on either side
            calm <= (p == 3);
            // long output hold-off while items keep coming
            if (p == 2 || p == 6)
                hold_seq <= hold_seq + 1;
            // request flood to fill the queue and force dropped inserts
            req_w = (p == 5) ? 50 : 30;
            for (int i = 0; i < PHASE_ITEMS; i++)
                offer_item(make_item(req_w), -1, '0, '0);
        end

        settle();
        $display("Ran %0d items (%0d directed) under %0d register settings, %0d results",
                 items_sent, items_directed, settings, results_seen);
        $display("%0d grants, %0d inserts dropped on a full queue, deepest queue %0d of %0d",
                 grants, drops, deepest, QUEUE_DEPTH);
        if (fail_count == 0)
            $display("Verification passed");
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
